// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the packetizer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packetizer check failed");

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packetizer check failed");

`endif

// ----- rtl/core/ptsp_pkg.sv -----
// Package for the PES to transport stream packetizer: constants, codes and
// the command record passed from the front end to the byte sequencer.
`default_nettype none

package ptsp_pkg;

  localparam int PACKET_BYTES    = 188;
  localparam int HDR_BYTES       = 4;
  localparam int ADAPT_BYTES     = 8;
  localparam int PES_BYTES       = 14;
  localparam int AUD_BYTES       = 6;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int PID_W   = 13;
  localparam int LEN_W   = 24;
  localparam int TS_W    = 33;
  localparam int ROOM_W  = 8;
  localparam int IDX_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [PID_W-1:0] VIDEO_PID_RST = 13'd120;
  localparam logic [PID_W-1:0] AUDIO_PID_RST = 13'd121;

  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_PID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_PID = 1'b1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [2:0] KIND_H264      = 3'd0;
  localparam logic [2:0] KIND_MPEG_VID  = 3'd1;
  localparam logic [2:0] KIND_AC3       = 3'd2;
  localparam logic [2:0] KIND_MPEG_AUD  = 3'd3;

  localparam logic [7:0] SYNC_BYTE  = 8'h47;
  localparam logic [7:0] SID_VIDEO  = 8'hE0;
  localparam logic [7:0] SID_AUDIO  = 8'hC0;
  localparam logic [7:0] SID_OTHER  = 8'h00;
  localparam logic [7:0] PES_FLAGS  = 8'h80;
  localparam logic [7:0] PES_HLEN   = 8'h05;
  localparam logic [7:0] AUD_NAL    = 8'h09;
  localparam logic [7:0] AUD_PIC    = 8'hE0;
  localparam logic [7:0] AF_LEN     = 8'h07;
  localparam logic [7:0] AF_FLAGS   = 8'h10;
  localparam logic [7:0] STUFF_BYTE = 8'hFF;

  typedef struct packed {
    logic              op;
    logic [PID_W-1:0]  pid;
    logic [3:0]        cc;
    logic              hdr;
    logic              adapt;
    logic [TS_W-1:0]   pcr;
    logic [7:0]        sid;
    logic [15:0]       total;
    logic [TS_W-1:0]   pts;
    logic              h264;
    logic              pad;
    logic [ROOM_W-1:0] pad_count;
    logic [7:0]        data;
    logic [IDX_W-1:0]  n_last;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/pes_to_transport_stream_packetizer_unit.sv -----
// Top level of the PES to transport stream packetizer: front end, command
// queue and byte sequencer. Depends on ptsp_pkg, ptsp_front, ptsp_queue, ptsp_back.
//
//   port group | direction | transfer rule
//   in_*       | input     | in_valid & in_ready, one start or data item
//   out_*      | output    | out_valid & out_ready, one stream byte with repeat count
//   cfg_*      | input     | cfg_we, register write, no wait
//
// A data item in a payload yields one result; a continuation packet adds 4
// or 12, padding adds 1. A start item yields 18 to 25 results. The byte
// sequencer emits one result per cycle unless out_ready stalls it; input is
// taken every cycle while the command queue (QUEUE_DEPTH entries) has room.
// Reset clears counters, PCR and payload state, restores PIDs 120 and 121.
`default_nettype none

module pes_to_transport_stream_packetizer_unit import ptsp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PID_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [PID_W-1:0]     in_track_pid,
  input  logic [2:0]           in_stream_kind,
  input  logic [LEN_W-1:0]     in_payload_length,
  input  logic [TS_W-1:0]      in_timestamp,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic [7:0]           out_repeat_count,
  output logic                 out_last
);

  logic push_valid, push_ready, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  ptsp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_track_pid      (in_track_pid),
    .in_stream_kind    (in_stream_kind),
    .in_payload_length (in_payload_length),
    .in_timestamp      (in_timestamp),
    .in_data_byte      (in_data_byte),
    .push_valid        (push_valid),
    .push_cmd          (push_cmd),
    .push_ready        (push_ready)
  );

  ptsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  ptsp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_repeat_count (out_repeat_count),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ptsp_front.sv -----
// Front end of the packetizer: config registers, payload and packet state,
// continuity counters and PCR; turns each start transfer and each data
// transfer inside a payload into a command. Depends on ptsp_pkg.
`default_nettype none

module ptsp_front import ptsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PID_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [PID_W-1:0]     in_track_pid,
  input  logic [2:0]           in_stream_kind,
  input  logic [LEN_W-1:0]     in_payload_length,
  input  logic [TS_W-1:0]      in_timestamp,
  input  logic [7:0]           in_data_byte,
  output logic                 push_valid,
  output cmd_t                 push_cmd,
  input  logic                 push_ready
);

  logic [PID_W-1:0]  video_pid_r, audio_pid_r;
  logic [3:0]        video_cnt_r, video_cnt_nxt, audio_cnt_r, audio_cnt_nxt;
  logic [TS_W-1:0]   pcr_r, pcr_nxt;
  logic [ROOM_W-1:0] room_r, room_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              toggle_r, toggle_nxt;
  logic [PID_W-1:0]  cur_pid_r, cur_pid_nxt;

  logic              accept;
  logic [PID_W-1:0]  pid_sel;
  logic              is_v, is_a;
  logic [3:0]        cc, cc_inc;
  logic              h264;
  logic [LEN_W:0]    total_w;
  logic [LEN_W-1:0]  left_dec;
  logic [ROOM_W-1:0] room_dec, room_base;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign pid_sel  = (in_op == OP_START) ? in_track_pid : cur_pid_r;
  assign is_v     = (pid_sel == video_pid_r);
  assign is_a     = (pid_sel == audio_pid_r);
  assign cc       = is_a ? audio_cnt_r : (is_v ? video_cnt_r : 4'd0);
  assign cc_inc   = cc + 4'd1;
  assign h264     = (in_stream_kind == KIND_H264);
  assign total_w  = {1'b0, in_payload_length} + (LEN_W+1)'(PES_BYTES - 6)
                  + (h264 ? (LEN_W+1)'(AUD_BYTES) : '0);
  assign left_dec = left_r - LEN_W'(1);
  assign room_dec = (room_r != '0) ? room_r - ROOM_W'(1) : '0;
  assign room_base = h264 ? ROOM_W'(PACKET_BYTES - HDR_BYTES - PES_BYTES - AUD_BYTES)
                          : ROOM_W'(PACKET_BYTES - HDR_BYTES - PES_BYTES);

  always_comb begin
    video_cnt_nxt = video_cnt_r;
    audio_cnt_nxt = audio_cnt_r;
    pcr_nxt       = pcr_r;
    room_nxt      = room_r;
    left_nxt      = left_r;
    toggle_nxt    = toggle_r;
    cur_pid_nxt   = cur_pid_r;
    push_valid    = 1'b0;
    push_cmd      = '0;
    push_cmd.op   = in_op;
    push_cmd.pid  = pid_sel;
    push_cmd.cc   = cc;
    push_cmd.pcr  = pcr_r;
    push_cmd.pts  = in_timestamp;
    push_cmd.h264 = h264;
    push_cmd.data = in_data_byte;
    push_cmd.total = (total_w > (LEN_W+1)'(16'hFFFF)) ? 16'd0 : total_w[15:0];
    case (in_stream_kind)
      KIND_H264, KIND_MPEG_VID: push_cmd.sid = SID_VIDEO;
      KIND_AC3, KIND_MPEG_AUD:  push_cmd.sid = SID_AUDIO;
      default:                  push_cmd.sid = SID_OTHER;
    endcase
    if (accept) begin
      if (in_op == OP_START) begin
        push_valid  = 1'b1;
        cur_pid_nxt = in_track_pid;
        toggle_nxt  = 1'b0;
        if (is_v) video_cnt_nxt = cc_inc;
        if (is_a) audio_cnt_nxt = cc_inc;
        left_nxt = in_payload_length;
        push_cmd.n_last = h264 ? IDX_W'(HDR_BYTES + PES_BYTES + AUD_BYTES - 1)
                               : IDX_W'(HDR_BYTES + PES_BYTES - 1);
        if (in_payload_length == '0) begin
          push_cmd.pad       = 1'b1;
          push_cmd.pad_count = room_base;
          push_cmd.n_last    = push_cmd.n_last + IDX_W'(1);
          room_nxt           = '0;
        end else begin
          room_nxt = room_base;
        end
      end else if (left_r != '0) begin
        push_valid      = 1'b1;
        left_nxt        = left_dec;
        room_nxt        = room_dec;
        push_cmd.n_last = '0;
        if (left_dec != '0) begin
          if (room_dec == '0) begin
            push_cmd.hdr   = 1'b1;
            push_cmd.adapt = toggle_r;
            toggle_nxt     = ~toggle_r;
            if (is_v) video_cnt_nxt = cc_inc;
            if (is_a) audio_cnt_nxt = cc_inc;
            if (toggle_r) begin
              pcr_nxt         = pcr_r + TS_W'(1);
              room_nxt        = ROOM_W'(PACKET_BYTES - HDR_BYTES - ADAPT_BYTES);
              push_cmd.n_last = IDX_W'(HDR_BYTES + ADAPT_BYTES);
            end else begin
              room_nxt        = ROOM_W'(PACKET_BYTES - HDR_BYTES);
              push_cmd.n_last = IDX_W'(HDR_BYTES);
            end
          end
        end else if (room_dec != '0) begin
          push_cmd.pad       = 1'b1;
          push_cmd.pad_count = room_dec;
          push_cmd.n_last    = IDX_W'(1);
          room_nxt           = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_pid_r <= VIDEO_PID_RST;
      audio_pid_r <= AUDIO_PID_RST;
      video_cnt_r <= '0;
      audio_cnt_r <= '0;
      pcr_r       <= '0;
      room_r      <= '0;
      left_r      <= '0;
      toggle_r    <= 1'b0;
      cur_pid_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VIDEO_PID: video_pid_r <= cfg_wdata;
          CFG_AUDIO_PID: audio_pid_r <= cfg_wdata;
          default: ;
        endcase
      end
      video_cnt_r <= video_cnt_nxt;
      audio_cnt_r <= audio_cnt_nxt;
      pcr_r       <= pcr_nxt;
      room_r      <= room_nxt;
      left_r      <= left_nxt;
      toggle_r    <= toggle_nxt;
      cur_pid_r   <= cur_pid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptsp_queue.sv -----
// Command queue between the packetizer front end and the byte sequencer.
// Small register file with read and write pointers. Depends on ptsp_pkg.
`default_nettype none

module ptsp_queue import ptsp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign q_valid    = (count_r != '0);
  assign q_cmd      = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CHK_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `CHK_SAME(a_no_push_full, clk, rst_n, push_valid, push_ready)
  `CHK_NEXT(a_last_pop_empty, clk, rst_n, pop && !push && (count_r == CNT_W'(1)), !q_valid)

endmodule

`default_nettype wire

// ----- rtl/core/ptsp_back.sv -----
// Byte sequencer of the packetizer: walks each queued command into the
// output register, one result per unstalled cycle. Depends on ptsp_pkg.
`default_nettype none

module ptsp_back import ptsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [7:0] out_repeat_count,
  output logic       out_last
);

  `include "assert_macros.svh"

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_rep_r;
  logic              out_last_r;
  logic              load, at_last;
  logic [7:0]        cur_byte, cur_rep;

  function automatic logic [7:0] hdr_byte(input cmd_t c, input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd0:    b = SYNC_BYTE;
      4'd1:    b = {1'b0, (c.op == OP_START), 1'b0, c.pid[12:8]};
      4'd2:    b = c.pid[7:0];
      4'd3:    b = {2'b00, c.adapt, 1'b1, c.cc};
      4'd4:    b = AF_LEN;
      4'd5:    b = AF_FLAGS;
      4'd6:    b = c.pcr[32:25];
      4'd7:    b = c.pcr[24:17];
      4'd8:    b = c.pcr[16:9];
      4'd9:    b = c.pcr[8:1];
      4'd10:   b = {c.pcr[0], 7'd0};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pes_byte(input cmd_t c, input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd2:    b = 8'h01;
      4'd3:    b = c.sid;
      4'd4:    b = c.total[15:8];
      4'd5:    b = c.total[7:0];
      4'd6:    b = PES_FLAGS;
      4'd7:    b = PES_FLAGS;
      4'd8:    b = PES_HLEN;
      4'd9:    b = {4'h2, c.pts[32:30], 1'b1};
      4'd10:   b = c.pts[29:22];
      4'd11:   b = {c.pts[21:15], 1'b1};
      4'd12:   b = c.pts[14:7];
      4'd13:   b = {c.pts[6:0], 1'b1};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] aud_byte(input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd3:    b = 8'h01;
      3'd4:    b = AUD_NAL;
      3'd5:    b = AUD_PIC;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  always_comb begin
    cur_byte = STUFF_BYTE;
    cur_rep  = q_cmd.pad_count;
    if (q_cmd.op == OP_START) begin
      if (idx_r < IDX_W'(HDR_BYTES)) begin
        cur_byte = hdr_byte(q_cmd, idx_r[3:0]);
        cur_rep  = 8'd1;
      end else if (idx_r < IDX_W'(HDR_BYTES + PES_BYTES)) begin
        cur_byte = pes_byte(q_cmd, 4'(idx_r - IDX_W'(HDR_BYTES)));
        cur_rep  = 8'd1;
      end else if (q_cmd.h264 && idx_r < IDX_W'(HDR_BYTES + PES_BYTES + AUD_BYTES)) begin
        cur_byte = aud_byte(3'(idx_r - IDX_W'(HDR_BYTES + PES_BYTES)));
        cur_rep  = 8'd1;
      end
    end else begin
      if (idx_r == '0) begin
        cur_byte = q_cmd.data;
        cur_rep  = 8'd1;
      end else if (q_cmd.hdr) begin
        cur_byte = hdr_byte(q_cmd, 4'(idx_r - IDX_W'(1)));
        cur_rep  = 8'd1;
      end
    end
  end

  assign load    = q_valid && (!out_valid_r || out_ready);
  assign at_last = (idx_r == q_cmd.n_last);
  assign q_pop   = load && at_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_rep_r  <= cur_rep;
      out_last_r <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_repeat_count = out_rep_r;
  assign out_last         = out_last_r;

  `CHK_SAME(a_idx_idle, clk, rst_n, !q_valid, idx_r == '0)
  `CHK_SAME(a_idx_bound, clk, rst_n, q_valid, idx_r <= q_cmd.n_last)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_byte_r))

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for pes_to_transport_stream_packetizer_unit.
// Predicts every stream byte from its own packetizer model and compares each out_* transfer.
// Depends on ptsp_pkg and the RTL under rtl/core only.
module tb;
  import ptsp_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_GAP = 32;
  localparam int DRAIN_GAP = 64;
  localparam int PHASE_ITEMS = 10;
  localparam int REPORT_MAX = 10;
  localparam int PES_TAIL = 8;
  localparam int UNCHECKED = -1;

  localparam logic [2:0] KIND_OTHER = 3'd4;
  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_MID = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;

  typedef struct packed {
    logic             op;
    logic [PID_W-1:0] pid;
    logic [2:0]       kind;
    logic [LEN_W-1:0] len;
    logic [TS_W-1:0]  ts;
    logic [7:0]       data;
  } ts_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] rep;
    logic       last;
  } ts_byte_t;

  typedef struct {
    ts_item_t   item;
    int         count;
    logic [7:0] tail_value;
    logic [7:0] tail_rep;
  } pes_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PID_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = 1'b0;
  logic [PID_W-1:0]     in_track_pid = '0;
  logic [2:0]           in_stream_kind = '0;
  logic [LEN_W-1:0]     in_payload_length = '0;
  logic [TS_W-1:0]      in_timestamp = '0;
  logic [7:0]           in_data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic [7:0]           out_repeat_count;
  logic                 out_last;

  // packetizer model state
  logic [PID_W-1:0] video_pid_r = VIDEO_PID_RST;
  logic [PID_W-1:0] audio_pid_r = AUDIO_PID_RST;
  logic [PID_W-1:0] cur_pid = '0;
  logic [3:0]       video_cc = '0;
  logic [3:0]       audio_cc = '0;
  logic [TS_W-1:0]  pcr_r = '0;
  logic             adapt_next = 1'b0;
  int               room = 0;
  int               bytes_due = 0;

  ts_byte_t burst[$];
  ts_byte_t ts_due[$];
  pes_row_t pes_rows[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int last_count = 0;
  int items_in = 0;
  int starts_in = 0;
  int results_seen = 0;
  int pcr_headers = 0;
  int cfg_writes = 0;
  int mismatches = 0;

  pes_to_transport_stream_packetizer_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_track_pid     (in_track_pid),
    .in_stream_kind   (in_stream_kind),
    .in_payload_length(in_payload_length),
    .in_timestamp     (in_timestamp),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_repeat_count (out_repeat_count),
    .out_last         (out_last)
  );

  initial forever #CLK_HALF clk = ~clk;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  function automatic void report(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] %s", $time, what);
  endfunction

  function automatic void put_byte(input logic [7:0] v, input logic [7:0] r);
    ts_byte_t e;
    e.value = v;
    e.rep = r;
    e.last = 1'b0;
    burst.push_back(e);
  endfunction

  function automatic void put_ts_header(input logic [PID_W-1:0] pid, input logic pusi,
                                        input logic adapt);
    logic [3:0] cc;
    logic is_v;
    logic is_a;
    is_v = (pid == video_pid_r);
    is_a = (pid == audio_pid_r);
    cc = 4'd0;
    if (is_v) cc = video_cc;
    if (is_a) cc = audio_cc;
    if (is_v) video_cc = cc + 4'd1;
    if (is_a) audio_cc = cc + 4'd1;
    put_byte(SYNC_BYTE, 8'd1);
    put_byte({1'b0, pusi, 1'b0, pid[12:8]}, 8'd1);
    put_byte(pid[7:0], 8'd1);
    put_byte({2'b00, adapt, 1'b1, cc}, 8'd1);
    if (adapt) begin
      put_byte(AF_LEN, 8'd1);
      put_byte(AF_FLAGS, 8'd1);
      put_byte(pcr_r[32:25], 8'd1);
      put_byte(pcr_r[24:17], 8'd1);
      put_byte(pcr_r[16:9], 8'd1);
      put_byte(pcr_r[8:1], 8'd1);
      put_byte({pcr_r[0], 7'd0}, 8'd1);
      put_byte(8'h00, 8'd1);
      pcr_r = pcr_r + 1'b1;
      pcr_headers++;
    end
  endfunction

  // Append the stream bytes one accepted item causes to ts_due; return their number.
  function automatic int packetize(input ts_item_t it);
    logic [7:0] sid;
    logic       adapt;
    int         total;
    burst.delete();
    if (it.op == OP_START) begin
      case (it.kind)
        KIND_H264, KIND_MPEG_VID: sid = SID_VIDEO;
        KIND_AC3, KIND_MPEG_AUD:  sid = SID_AUDIO;
        default:                  sid = SID_OTHER;
      endcase
      total = int'(it.len) + PES_TAIL + ((it.kind == KIND_H264) ? AUD_BYTES : 0);
      if (total > 32'hFFFF) total = 0;
      cur_pid = it.pid;
      adapt_next = 1'b0;
      put_ts_header(it.pid, 1'b1, 1'b0);
      put_byte(8'h00, 8'd1);
      put_byte(8'h00, 8'd1);
      put_byte(8'h01, 8'd1);
      put_byte(sid, 8'd1);
      put_byte(total[15:8], 8'd1);
      put_byte(total[7:0], 8'd1);
      put_byte(PES_FLAGS, 8'd1);
      put_byte(PES_FLAGS, 8'd1);
      put_byte(PES_HLEN, 8'd1);
      put_byte({4'h2, it.ts[32:30], 1'b1}, 8'd1);
      put_byte(it.ts[29:22], 8'd1);
      put_byte({it.ts[21:15], 1'b1}, 8'd1);
      put_byte(it.ts[14:7], 8'd1);
      put_byte({it.ts[6:0], 1'b1}, 8'd1);
      if (it.kind == KIND_H264) begin
        put_byte(8'h00, 8'd1);
        put_byte(8'h00, 8'd1);
        put_byte(8'h00, 8'd1);
        put_byte(8'h01, 8'd1);
        put_byte(AUD_NAL, 8'd1);
        put_byte(AUD_PIC, 8'd1);
      end
      room = PACKET_BYTES - burst.size();
      bytes_due = int'(it.len);
      if (bytes_due == 0) begin
        put_byte(STUFF_BYTE, room[7:0]);
        room = 0;
      end
    end else if (bytes_due > 0) begin
      put_byte(it.data, 8'd1);
      bytes_due--;
      if (room > 0) room--;
      if (bytes_due > 0) begin
        if (room == 0) begin
          adapt = adapt_next;
          put_ts_header(cur_pid, 1'b0, adapt);
          adapt_next = ~adapt_next;
          room = PACKET_BYTES - HDR_BYTES - (adapt ? ADAPT_BYTES : 0);
        end
      end else if (room > 0) begin
        put_byte(STUFF_BYTE, room[7:0]);
        room = 0;
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[k]) ts_due.push_back(burst[k]);
    return burst.size();
  endfunction

  function automatic void add_row(input logic op, input logic [PID_W-1:0] pid,
                                  input logic [2:0] kind, input logic [LEN_W-1:0] len,
                                  input logic [TS_W-1:0] ts, input logic [7:0] data,
                                  input int count, input logic [7:0] tail_value,
                                  input logic [7:0] tail_rep);
    pes_row_t r;
    r.item = '{op: op, pid: pid, kind: kind, len: len, ts: ts, data: data};
    r.count = count;
    r.tail_value = tail_value;
    r.tail_rep = tail_rep;
    pes_rows.push_back(r);
  endfunction

  function automatic ts_item_t junk_item();
    ts_item_t it;
    it.op = 1'($urandom_range(1));
    it.pid = PID_W'($urandom);
    it.kind = 3'($urandom);
    it.len = LEN_W'($urandom);
    it.ts = TS_W'({$urandom, $urandom});
    it.data = 8'($urandom);
    return it;
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    case ($urandom_range(3))
      0:       return video_pid_r;
      1:       return audio_pid_r;
      default: return PID_W'($urandom);
    endcase
  endfunction

  // out_* transfers: checked at the falling edge, before the edge that moves them
  always @(negedge clk) begin
    ts_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (ts_due.size() == 0) begin
        report($sformatf("unexpected transfer: got %h x%0d last %b",
                         out_byte, out_repeat_count, out_last));
      end else begin
        want = ts_due.pop_front();
        if (out_byte !== want.value || out_repeat_count !== want.rep ||
            out_last !== want.last) begin
          report($sformatf("transfer %0d: expected %h x%0d last %b, got %h x%0d last %b",
                           results_seen, want.value, want.rep, want.last,
                           out_byte, out_repeat_count, out_last));
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic offer(input ts_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_track_pid <= it.pid;
    in_stream_kind <= it.kind;
    in_payload_length <= it.len;
    in_timestamp <= it.ts;
    in_data_byte <= it.data;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_in++;
    if (it.op == OP_START) starts_in++;
    last_count = packetize(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PID_W-1:0] val);
    wait_drained();
    repeat (IDLE_GAP) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_VIDEO_PID) video_pid_r = val;
    else audio_pid_r = val;
    cfg_writes++;
  endtask

  task automatic send_data(input int count);
    ts_item_t it;
    repeat (count) begin
      it = junk_item();
      it.op = OP_DATA;
      offer(it);
    end
  endtask

  task automatic send_payload(input logic [PID_W-1:0] pid, input logic [2:0] kind,
                              input int len);
    ts_item_t it;
    it = junk_item();
    it.op = OP_START;
    it.pid = pid;
    it.kind = kind;
    it.len = LEN_W'(len);
    offer(it);
    send_data(len);
  endtask

  // Mostly complete payloads; some abandoned starts with any length, some stray data.
  task automatic random_phase(input int quota);
    ts_item_t it;
    int       goal;
    int       sel;
    goal = items_in + quota;
    while (items_in < goal) begin
      sel = $urandom_range(99);
      it = junk_item();
      if (sel < 85) begin
        it.op = OP_START;
        it.pid = pick_pid();
        if (sel < 70) begin
          it.len = LEN_W'($urandom_range(12));
          offer(it);
          send_data(int'(it.len));
        end else begin
          offer(it);
          send_data(int'($urandom_range(4)));
        end
      end else begin
        send_data(int'($urandom_range(1, 3)));
      end
    end
  endtask

  initial begin
    logic [PID_W-1:0] shared_pid;
    ts_byte_t         tail;

    add_row(OP_START, 13'd120, KIND_MPEG_VID, 24'd0, 33'd0, 8'h00, 19, STUFF_BYTE, 8'd170);
    add_row(OP_START, 13'd121, KIND_MPEG_AUD, 24'd0, 33'h1_FFFF_FFFF, 8'h00,
            19, STUFF_BYTE, 8'd170);
    add_row(OP_START, 13'd8191, KIND_H264, 24'd0, 33'd0, 8'hFF, 25, STUFF_BYTE, 8'd164);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'hA5, 0, 8'h00, 8'd0);
    add_row(OP_START, 13'd0, KIND_OTHER, 24'd2, 33'h0_AAAA_AAAA, 8'h00, UNCHECKED, 8'h00, 8'd0);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'h00, 1, 8'h00, 8'd1);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'hFF, 2, STUFF_BYTE, 8'd168);
    add_row(OP_START, 13'd120, KIND_AC3, 24'd65527, 33'd1, 8'h00, UNCHECKED, 8'h00, 8'd0);
    add_row(OP_START, 13'd121, KIND_H264, 24'd65521, 33'd2, 8'h00, 24, AUD_PIC, 8'd1);
    add_row(OP_START, 13'd5, KIND_H264, 24'd65522, 33'd3, 8'h00, 24, AUD_PIC, 8'd1);
    add_row(OP_START, 13'd6, KIND_MPEG_VID, 24'd65528, 33'd4, 8'h00, UNCHECKED, 8'h00, 8'd0);
    add_row(OP_START, 13'd7, KIND_RSVD_HI, 24'hFFFFFF, 33'h0_1234_5678, 8'h00,
            UNCHECKED, 8'h00, 8'd0);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'h5A, 1, 8'h5A, 8'd1);
    add_row(OP_START, 13'd120, KIND_RSVD_LO, 24'd1, 33'h1_8000_0001, 8'h00,
            UNCHECKED, 8'h00, 8'd0);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'h80, 2, STUFF_BYTE, 8'd169);
    add_row(OP_START, 13'd121, KIND_RSVD_MID, 24'd3, 33'h1_5555_5555, 8'h00,
            UNCHECKED, 8'h00, 8'd0);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'h01, 1, 8'h01, 8'd1);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'h7F, 1, 8'h7F, 8'd1);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'hFE, 2, STUFF_BYTE, 8'd167);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'h33, 0, 8'h00, 8'd0);
    add_row(OP_START, 13'd8191, KIND_AC3, 24'd1, 33'h1_0000_0000, 8'h00,
            UNCHECKED, 8'h00, 8'd0);
    add_row(OP_DATA, 13'd0, KIND_H264, 24'd0, 33'd0, 8'hC3, 2, STUFF_BYTE, 8'd169);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (pes_rows[r]) begin
      offer(pes_rows[r].item);
      if (pes_rows[r].count != UNCHECKED) begin
        if (last_count != pes_rows[r].count) begin
          report($sformatf("row %0d: expected %0d transfers, model gives %0d",
                           r, pes_rows[r].count, last_count));
        end else if (last_count > 0) begin
          tail = burst[burst.size()-1];
          if (tail.value !== pes_rows[r].tail_value || tail.rep !== pes_rows[r].tail_rep)
            report($sformatf("row %0d: expected tail %h x%0d, model gives %h x%0d", r,
                             pes_rows[r].tail_value, pes_rows[r].tail_rep,
                             tail.value, tail.rep));
        end
      end
    end

    write_reg(CFG_VIDEO_PID, '0);
    write_reg(CFG_AUDIO_PID, '1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(PHASE_ITEMS);
    // stall the output so the input backs up during a long payload
    hold_off = 400;
    send_payload(video_pid_r, KIND_H264, 352);
    wait_drained();

    shared_pid = PID_W'($urandom);
    write_reg(CFG_VIDEO_PID, shared_pid);
    write_reg(CFG_AUDIO_PID, shared_pid);
    send_idle_pct = 85;
    recv_stall_pct = 0;
    random_phase(PHASE_ITEMS);

    write_reg(CFG_VIDEO_PID, PID_W'($urandom));
    write_reg(CFG_AUDIO_PID, PID_W'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 85;
    random_phase(PHASE_ITEMS);

    write_reg(CFG_VIDEO_PID, '1);
    write_reg(CFG_AUDIO_PID, '0);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    random_phase(PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_GAP) @(posedge clk);
    if (ts_due.size() != 0) report($sformatf("%0d transfers never arrived", ts_due.size()));

    $display("covered %0d input transfers (%0d payload starts), %0d output transfers,",
             items_in, starts_in, results_seen);
    $display("  %0d PCR headers, %0d register writes, four idle/stall mixes, %0d mismatches",
             pcr_headers, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
